// File: rtl/lpsb_pkg.sv
package lpsb_pkg;

    localparam int unsigned ByteW  = 8;
    localparam int unsigned DistW  = 11;
    localparam int unsigned TolW   = 14;
    localparam int unsigned AngW   = 19;
    localparam logic [AngW-1:0] FullTurn    = 19'd368640;
    localparam logic [AngW-1:0] HalfTurn    = 19'd184320;
    localparam logic [AngW-1:0] QuarterTurn = 19'd92160;
    localparam logic [TolW-1:0] TolReset    = 14'd320;
    localparam logic [ByteW-1:0] HdrFirst   = 8'hAA;
    localparam logic [ByteW-1:0] HdrSecond  = 8'h55;

    typedef logic [DistW-1:0] dist_t;

    typedef struct packed {
        dist_t front_first;
        dist_t front_second;
        dist_t right_first;
        dist_t right_second;
        dist_t back_first;
        dist_t back_second;
        dist_t left_first;
    } result_t;

    // shared divider command/status
    typedef struct packed {
        logic             start;
        logic [AngW-1:0]  dividend;
        logic [ByteW-1:0] divisor;
    } div_cmd_t;

    typedef struct packed {
        logic             busy;
        logic [AngW-1:0]  quotient;
    } div_sts_t;

endpackage

// File: rtl/lpsb_if.sv
interface lpsb_byte_if;
    logic                     valid;
    logic                     ready;
    logic [lpsb_pkg::ByteW-1:0] rx_byte;
    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface lpsb_cfg_if;
    logic                     valid;
    logic                     ready;
    logic [lpsb_pkg::TolW-1:0] tol_word;
    modport source (output valid, output tol_word, input ready);
    modport sink (input valid, input tol_word, output ready);
endinterface

interface lpsb_res_if;
    logic                 valid;
    logic                 ready;
    lpsb_pkg::result_t    data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: rtl/lpsb_divider.sv
// Restoring divider, one quotient bit a cycle.
module lpsb_divider
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  lpsb_pkg::div_cmd_t   cmd,
    output lpsb_pkg::div_sts_t   sts
);
    localparam int unsigned CntW = $clog2(lpsb_pkg::AngW + 1);

    logic [lpsb_pkg::AngW-1:0]  quo_reg, quo_next;
    logic [lpsb_pkg::ByteW:0]   rem_reg, rem_next;
    logic [lpsb_pkg::ByteW-1:0] dvs_reg, dvs_next;
    logic [CntW-1:0]            cnt_reg, cnt_next;
    logic [lpsb_pkg::ByteW:0]   trial;

    always_comb
    begin
        quo_next = quo_reg;
        rem_next = rem_reg;
        dvs_next = dvs_reg;
        cnt_next = cnt_reg;
        trial    = {rem_reg[lpsb_pkg::ByteW-1:0], quo_reg[lpsb_pkg::AngW-1]};
        if (cmd.start)
        begin
            quo_next = cmd.dividend;
            rem_next = '0;
            dvs_next = cmd.divisor;
            cnt_next = CntW'(lpsb_pkg::AngW);
        end
        else if (cnt_reg != '0)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = trial - {1'b0, dvs_reg};
                quo_next = {quo_reg[lpsb_pkg::AngW-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                quo_next = {quo_reg[lpsb_pkg::AngW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign sts.busy     = (cnt_reg != '0);
    assign sts.quotient = quo_reg;
endmodule

// File: rtl/lidar_packet_sector_binner.sv
// Channel   | Dir | Payload
// in_ch     | in  | rx_byte[7:0]
// cfg_ch    | in  | tol_word[13:0], angle tolerance in 1/64 degree
// out_ch    | out | seven 11-bit sector distances (result_t)
// Header, angle and checksum-low beats are taken back to back. The checksum-high
// beat with count above 1 holds input for divider load, 19 quotient bits, store.
// Data beats pass W_DONE; distance high beat: reciprocal mm/10, 4 compares.
// Reset clears parser state, slots and hit counts; no clearing pass.
// A finished result waits in the output register; input also stalls while a
// new result is due and the old one is still untaken.
module lidar_packet_sector_binner
(
    input logic          clk,
    input logic          rst_n,
    lpsb_byte_if.sink    in_ch,
    lpsb_cfg_if.sink     cfg_ch,
    lpsb_res_if.source   out_ch
);
    typedef enum logic [3:0] {
        S_HDR1, S_HDR2, S_TYPE, S_COUNT, S_FLO, S_FHI, S_LLO, S_LHI,
        S_CLO, S_CHI, S_DATA
    } phase_t;
    typedef enum logic [2:0] {W_IDLE, W_DIVLD, W_DIVRUN, W_CM, W_BIN, W_DONE} work_t;

    localparam int unsigned AW = lpsb_pkg::AngW;

    phase_t            ph_reg;
    work_t             wk_reg;
    logic [13:0]       tol_reg;
    logic              flag_reg;
    logic [7:0]        cnt_reg;
    logic [15:0]       fa_reg, la_reg;
    logic [9:0]        dbc_reg;
    logic [1:0]        pos_reg;
    logic [7:0]        low_reg;
    logic [AW-1:0]     step_reg, ang_reg;
    lpsb_pkg::dist_t   dist_reg [7];
    logic [1:0]        hits_reg [4];
    lpsb_pkg::result_t snap_reg;
    logic              ov_reg;
    lpsb_pkg::result_t od_reg;
    logic [13:0]       mm_reg;
    logic [10:0]       cm_reg;
    logic [1:0]        k_reg;
    logic              last_reg;

    lpsb_pkg::div_cmd_t dcmd;
    lpsb_pkg::div_sts_t dsts;

    lpsb_divider u_div (.clk(clk), .rst_n(rst_n), .cmd(dcmd), .sts(dsts));

    function automatic logic [AW-1:0] angle_of(input logic [15:0] raw);
        logic [AW-1:0] a;
        a = {raw[15:1], 4'b0};
        if (a >= lpsb_pkg::FullTurn)
            a = a - lpsb_pkg::FullTurn;
        return a;
    endfunction

    logic [AW-1:0] a0, a1, span;
    always_comb
    begin
        a0 = angle_of(fa_reg);
        a1 = angle_of(la_reg);
        span = (a1 >= a0) ? a1 - a0 : a1 + lpsb_pkg::FullTurn - a0;
        dcmd.start    = (wk_reg == W_DIVLD);
        dcmd.dividend = span;
        dcmd.divisor  = cnt_reg - 8'd1;
    end

    // shared compare unit: sector k center distance
    logic [AW-1:0] center, dd;
    logic          near;
    always_comb
    begin
        center = AW'(k_reg) * lpsb_pkg::QuarterTurn;
        dd = (ang_reg >= center) ? ang_reg - center : center - ang_reg;
        if (dd > lpsb_pkg::HalfTurn)
            dd = lpsb_pkg::FullTurn - dd;
        near = (dd <= {1'b0, tol_reg, 4'b0});
    end

    // mm/10 as mm * ceil(2^19/10) >> 19, exact for any 14-bit mm
    logic [29:0] cm_prod;
    assign cm_prod = 30'(mm_reg) * 30'd52429;

    // sum is one bit wider: angle plus step can pass 2^19
    logic [AW:0] ang_sum;
    always_comb
    begin
        ang_sum = {1'b0, ang_reg} + {1'b0, step_reg};
        if (ang_sum >= {1'b0, lpsb_pkg::FullTurn})
            ang_sum = ang_sum - {1'b0, lpsb_pkg::FullTurn};
    end

    logic acc;
    assign acc = in_ch.valid && in_ch.ready;
    assign in_ch.ready  = (wk_reg == W_IDLE);
    assign cfg_ch.ready = 1'b1;
    assign out_ch.valid = ov_reg;
    assign out_ch.data  = od_reg;

    // result due now; hold in W_DONE while the previous one is untaken
    logic emit, done_hold;
    assign emit      = (wk_reg == W_DONE) && last_reg && flag_reg;
    assign done_hold = emit && ov_reg && !out_ch.ready;

    logic [9:0] dbc_inc;
    assign dbc_inc = dbc_reg + 10'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph_reg   <= S_HDR1;
            wk_reg   <= W_IDLE;
            tol_reg  <= lpsb_pkg::TolReset;
            flag_reg <= 1'b0;
            cnt_reg  <= '0;
            fa_reg   <= '0;
            la_reg   <= '0;
            dbc_reg  <= '0;
            pos_reg  <= '0;
            low_reg  <= '0;
            step_reg <= '0;
            ang_reg  <= '0;
            ov_reg   <= 1'b0;
            od_reg   <= '0;
            snap_reg <= '0;
            mm_reg   <= '0;
            cm_reg   <= '0;
            k_reg    <= '0;
            last_reg <= 1'b0;
            for (int i = 0; i < 7; i++)
                dist_reg[i] <= '0;
            for (int i = 0; i < 4; i++)
                hits_reg[i] <= '0;
        end
        else
        begin
            if (cfg_ch.valid)
                tol_reg <= cfg_ch.tol_word;
            if (emit && !done_hold)
                ov_reg <= 1'b1;
            else if (ov_reg && out_ch.ready)
                ov_reg <= 1'b0;
            case (wk_reg)
                W_IDLE:
                begin
                    if (acc)
                    begin
                        case (ph_reg)
                            S_HDR1:
                                if (in_ch.rx_byte == lpsb_pkg::HdrFirst)
                                    ph_reg <= S_HDR2;
                            S_HDR2:
                                ph_reg <= (in_ch.rx_byte == lpsb_pkg::HdrSecond) ?
                                          S_TYPE : S_HDR1;
                            S_TYPE:
                            begin
                                flag_reg <= in_ch.rx_byte[0];
                                if (in_ch.rx_byte[0])
                                begin
                                    snap_reg <= {dist_reg[0], dist_reg[1], dist_reg[2],
                                                 dist_reg[3], dist_reg[4], dist_reg[5],
                                                 dist_reg[6]};
                                    for (int i = 0; i < 7; i++)
                                        dist_reg[i] <= '0;
                                    for (int i = 0; i < 4; i++)
                                        hits_reg[i] <= '0;
                                end
                                ph_reg <= S_COUNT;
                            end
                            S_COUNT:
                            begin
                                cnt_reg <= in_ch.rx_byte;
                                ph_reg  <= S_FLO;
                            end
                            S_FLO:
                            begin
                                fa_reg <= {8'h00, in_ch.rx_byte};
                                ph_reg <= S_FHI;
                            end
                            S_FHI:
                            begin
                                fa_reg[15:8] <= in_ch.rx_byte;
                                ph_reg       <= S_LLO;
                            end
                            S_LLO:
                            begin
                                la_reg <= {8'h00, in_ch.rx_byte};
                                ph_reg <= S_LHI;
                            end
                            S_LHI:
                            begin
                                la_reg[15:8] <= in_ch.rx_byte;
                                ph_reg       <= S_CLO;
                            end
                            S_CLO: ph_reg <= S_CHI;
                            S_CHI:
                            begin
                                ang_reg <= a0;
                                dbc_reg <= '0;
                                pos_reg <= '0;
                                ph_reg  <= S_DATA;
                                if (cnt_reg > 8'd1)
                                    wk_reg <= W_DIVLD;
                                else
                                    step_reg <= '0;
                            end
                            default:
                            begin
                                dbc_reg  <= dbc_inc;
                                pos_reg  <= (pos_reg == 2'd2) ? 2'd0 : pos_reg + 2'd1;
                                last_reg <= ({1'b0, dbc_inc} >= 11'(cnt_reg) * 11'd3);
                                if (pos_reg == 2'd1)
                                    low_reg <= in_ch.rx_byte;
                                if (pos_reg == 2'd2)
                                begin
                                    mm_reg <= {in_ch.rx_byte, low_reg[7:2]};
                                    k_reg  <= 2'd0;
                                    wk_reg <= W_CM;
                                end
                                else
                                    wk_reg <= W_DONE;
                            end
                        endcase
                    end
                end
                W_DIVLD: wk_reg <= W_DIVRUN;
                W_DIVRUN:
                    if (!dsts.busy)
                    begin
                        step_reg <= dsts.quotient;
                        wk_reg   <= W_IDLE;
                    end
                W_CM:
                begin
                    cm_reg <= cm_prod[29:19];
                    wk_reg <= W_BIN;
                end
                W_BIN:
                begin
                    // zero distance is skipped, angle still advances
                    if (near && mm_reg != '0)
                    begin
                        if (k_reg == 2'd3)
                        begin
                            if (hits_reg[3] == 2'd0)
                            begin
                                dist_reg[6] <= cm_reg;
                                hits_reg[3] <= 2'd1;
                            end
                        end
                        else if (hits_reg[k_reg] < 2'd2)
                        begin
                            dist_reg[{k_reg, hits_reg[k_reg][0]}] <= cm_reg;
                            hits_reg[k_reg] <= hits_reg[k_reg] + 2'd1;
                        end
                    end
                    if (k_reg == 2'd3)
                    begin
                        ang_reg <= ang_sum[AW-1:0];
                        wk_reg  <= W_DONE;
                    end
                    else
                        k_reg <= k_reg + 2'd1;
                end
                W_DONE:
                begin
                    if (!done_hold)
                    begin
                        if (last_reg)
                        begin
                            if (flag_reg)
                            begin
                                od_reg   <= snap_reg;
                                flag_reg <= 1'b0;
                            end
                            ph_reg <= S_HDR1;
                        end
                        wk_reg <= W_IDLE;
                    end
                end
                default: wk_reg <= W_IDLE;
            endcase
        end
    end
endmodule

// File: test/lpsb_tb_if.sv
`timescale 1ns / 1ps

// Interfaces come from the RTL's own file; this file only holds the parser phase
// type and sector indices used by the bench's predictor.
package lpsb_tb_pkg;

    typedef enum logic [3:0] {
        PH_HDR1,
        PH_HDR2,
        PH_TYPE,
        PH_COUNT,
        PH_FSA_LO,
        PH_FSA_HI,
        PH_LSA_LO,
        PH_LSA_HI,
        PH_CS_LO,
        PH_CS_HI,
        PH_DATA
    } parse_phase_t;

    localparam int unsigned SecFront = 0;
    localparam int unsigned SecRight = 1;
    localparam int unsigned SecBack  = 2;
    localparam int unsigned SecLeft  = 3;

endpackage

// File: test/lidar_packet_sector_binner_tb.sv
`timescale 1ns / 1ps

module lidar_packet_sector_binner_tb;

    localparam int unsigned WatchLimit = 20000;
    localparam int unsigned DrainCycles = 200;

    logic clk;
    logic rst_n;

    lpsb_byte_if in_ch ();
    lpsb_cfg_if  cfg_ch ();
    lpsb_res_if  out_ch ();

    lidar_packet_sector_binner dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .cfg_ch (cfg_ch.sink),
        .out_ch (out_ch.source)
    );

    // ---- predictor state: mirrors the parser and the sector slots ----
    lpsb_tb_pkg::parse_phase_t phase;
    logic              pkt_flag;
    logic [7:0]        pkt_count;
    logic [15:0]       raw_start;
    logic [15:0]       raw_end;
    logic [9:0]        byte_idx;
    logic [7:0]        low_byte;
    logic [19:0]       step;
    logic [19:0]       cur_angle;
    lpsb_pkg::dist_t   slots [7];
    logic [1:0]        hits [4];
    lpsb_pkg::result_t held_snap;
    logic              snap_due;
    logic [13:0]       tol;

    lpsb_pkg::result_t scan_q [$];   // expected sector reports, oldest first
    int       errors = 0;
    int       idle_cycles = 0;
    logic     gaps_on;      // random idling on both sides

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [19:0] to_angle(logic [15:0] raw);
        logic [19:0] a;
        a = 20'(raw >> 1) * 20'd16;
        if (a >= 20'd368640)
            a = a - 20'd368640;
        return a;
    endfunction

    function automatic logic hit_near(logic [19:0] a, logic [19:0] c, logic [13:0] t);
        logic [19:0] d;
        d = (a >= c) ? a - c : c - a;
        if (d > 20'd184320)
            d = 20'd368640 - d;
        return d <= 20'(t) * 20'd16;
    endfunction

    task automatic bin_hit(logic [19:0] a, lpsb_pkg::dist_t cm);
        logic [19:0] centers [4];
        int unsigned cap;
        centers[lpsb_tb_pkg::SecFront] = 20'd0;
        centers[lpsb_tb_pkg::SecRight] = 20'd92160;
        centers[lpsb_tb_pkg::SecBack]  = 20'd184320;
        centers[lpsb_tb_pkg::SecLeft]  = 20'd276480;
        for (int s = 0; s < 4; s++)
        begin
            cap = (s == lpsb_tb_pkg::SecLeft) ? 1 : 2;
            if (hit_near(a, centers[s], tol) && hits[s] < cap)
            begin
                slots[s * 2 + hits[s]] = cm;
                hits[s] = hits[s] + 2'd1;
            end
        end
    endtask

    // Advances the parser model by one accepted byte.
    task automatic predict_byte(logic [7:0] b);
        logic [19:0] a0;
        logic [19:0] a1;
        logic [19:0] span;
        logic [19:0] mm;
        case (phase)
            lpsb_tb_pkg::PH_HDR1:
                if (b == lpsb_pkg::HdrFirst)
                    phase = lpsb_tb_pkg::PH_HDR2;
            lpsb_tb_pkg::PH_HDR2:
                phase = (b == lpsb_pkg::HdrSecond) ? lpsb_tb_pkg::PH_TYPE
                                                   : lpsb_tb_pkg::PH_HDR1;
            lpsb_tb_pkg::PH_TYPE:
            begin
                pkt_flag = b[0];
                if (pkt_flag)
                begin
                    held_snap = {slots[0], slots[1], slots[2], slots[3],
                                 slots[4], slots[5], slots[6]};
                    for (int i = 0; i < 7; i++) slots[i] = '0;
                    for (int i = 0; i < 4; i++) hits[i] = '0;
                end
                snap_due = pkt_flag;
                phase = lpsb_tb_pkg::PH_COUNT;
            end
            lpsb_tb_pkg::PH_COUNT:
            begin
                pkt_count = b;
                phase = lpsb_tb_pkg::PH_FSA_LO;
            end
            lpsb_tb_pkg::PH_FSA_LO:
            begin
                raw_start = {8'h00, b};
                phase = lpsb_tb_pkg::PH_FSA_HI;
            end
            lpsb_tb_pkg::PH_FSA_HI:
            begin
                raw_start[15:8] = b;
                phase = lpsb_tb_pkg::PH_LSA_LO;
            end
            lpsb_tb_pkg::PH_LSA_LO:
            begin
                raw_end = {8'h00, b};
                phase = lpsb_tb_pkg::PH_LSA_HI;
            end
            lpsb_tb_pkg::PH_LSA_HI:
            begin
                raw_end[15:8] = b;
                phase = lpsb_tb_pkg::PH_CS_LO;
            end
            lpsb_tb_pkg::PH_CS_LO: phase = lpsb_tb_pkg::PH_CS_HI;
            lpsb_tb_pkg::PH_CS_HI:
            begin
                a0 = to_angle(raw_start);
                a1 = to_angle(raw_end);
                span = (a1 >= a0) ? a1 - a0 : a1 + 20'd368640 - a0;
                step = (pkt_count > 1) ? span / 20'(pkt_count - 8'd1) : '0;
                cur_angle = a0;
                byte_idx = '0;
                phase = lpsb_tb_pkg::PH_DATA;
            end
            default:
            begin
                if (byte_idx % 3 == 1)
                    low_byte = b;
                else if (byte_idx % 3 == 2)
                begin
                    mm = (20'(b) << 6) | 20'(low_byte >> 2);
                    if (mm != 0)
                        bin_hit(cur_angle, lpsb_pkg::dist_t'(mm / 10));
                    cur_angle = cur_angle + step;
                    if (cur_angle >= 20'd368640)
                        cur_angle = cur_angle - 20'd368640;
                end
                byte_idx = byte_idx + 10'd1;
                if (32'(byte_idx) >= 32'(pkt_count) * 3)
                begin
                    if (snap_due)
                    begin
                        scan_q.push_back(held_snap);
                        snap_due = 1'b0;
                    end
                    phase = lpsb_tb_pkg::PH_HDR1;
                end
            end
        endcase
    endtask

    task automatic idle_burst();
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
    endtask

    // Sends one byte beat and updates the predictor on acceptance.
    // Ready is checked at the falling edge, where it is stable.
    task automatic send_byte(logic [7:0] b);
        idle_burst();
        in_ch.valid   <= 1'b1;
        in_ch.rx_byte <= b;
        @(negedge clk);
        while (!in_ch.ready) @(negedge clk);
        @(posedge clk);
        predict_byte(b);
    endtask

    task automatic send_frame(logic [7:0] ptype, logic [7:0] cnt,
                              logic [15:0] sa, logic [15:0] ea,
                              logic force_hit, logic [13:0] mm_max);
        logic [13:0] mm;
        send_byte(lpsb_pkg::HdrFirst);
        send_byte(lpsb_pkg::HdrSecond);
        send_byte(ptype);
        send_byte(cnt);
        send_byte(sa[7:0]);
        send_byte(sa[15:8]);
        send_byte(ea[7:0]);
        send_byte(ea[15:8]);
        send_byte(8'($urandom));
        send_byte(8'($urandom));
        if (cnt == 0)
            send_byte(8'($urandom));
        for (int i = 0; i < cnt; i++)
        begin
            mm = force_hit ? 14'($urandom_range(0, mm_max)) : 14'($urandom);
            send_byte(8'($urandom));
            send_byte({mm[5:0], 2'($urandom)});
            send_byte(mm[13:6]);
        end
    endtask

    // Waits for every expected report, then lets the block run on with input idle.
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (scan_q.size() != 0) @(posedge clk);
        repeat (DrainCycles) @(posedge clk);
    endtask

    task automatic write_tol(logic [13:0] t);
        drain();
        cfg_ch.valid    <= 1'b1;
        cfg_ch.tol_word <= t;
        @(negedge clk);
        while (!cfg_ch.ready) @(negedge clk);
        @(posedge clk);
        tol = t;
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic logic [15:0] raw_of_deg64(int unsigned d64);
        return 16'((d64 << 1) | $urandom_range(0, 1));
    endfunction

    // Header edge cases, zero and single counts, checksum ignored.
    task automatic test_framing();
        send_byte(8'h00);
        send_byte(lpsb_pkg::HdrFirst);
        send_byte(8'h54);                   // bad second header byte
        send_byte(8'hFF);
        send_frame(8'h01, 8'd0, 16'h0000, 16'hFFFF, 1'b1, 14'h3FFF);
        send_frame(8'h00, 8'd1, 16'hFFFF, 16'h0000, 1'b1, 14'h3FFF);
        send_frame(8'hFE, 8'd0, 16'h0000, 16'h0000, 1'b1, 14'h3FFF);
        send_frame(8'h01, 8'd2, 16'h0000, 16'h0000, 1'b1, 14'h3FFF);
    endtask

    // Samples spread over a full turn, then frames of zero distances.
    task automatic test_sectors();
        send_frame(8'h01, 8'd40, 16'h0000, raw_of_deg64(22500), 1'b1, 14'h3FFF);
        send_frame(8'h03, 8'd60, raw_of_deg64(5760), raw_of_deg64(5700), 1'b1, 14'h3FFF);
        send_frame(8'h01, 8'd3, 16'h0000, 16'h0000, 1'b1, 14'd0);  // zero distances
        send_frame(8'h01, 8'd1, 16'h0000, 16'h0000, 1'b1, 14'd0);
    endtask

    task automatic test_random(int unsigned n_bytes);
        int unsigned start_cnt;
        int unsigned c;
        start_cnt = 0;
        while (start_cnt < n_bytes)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                send_byte($urandom_range(0, 1) ? lpsb_pkg::HdrFirst : 8'($urandom));
                start_cnt++;
            end
            else
            begin
                c = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 255)
                                                 : $urandom_range(0, 12);
                send_frame(8'($urandom) | 8'($urandom_range(0, 1)), 8'(c),
                           raw_of_deg64($urandom_range(0, 32767)),
                           raw_of_deg64($urandom_range(0, 32767)),
                           $urandom_range(0, 3) != 0, 14'($urandom_range(0, 16383)));
                start_cnt += 10 + 3 * c;
            end
        end
    endtask

    // Result side: a beat seen at the falling edge is taken at the next rise.
    always @(negedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (scan_q.size() == 0)
            begin
                $display("%0t: unexpected report, actual %h", $time, out_ch.data);
                errors++;
            end
            else
            begin
                lpsb_pkg::result_t e;
                e = scan_q.pop_front();
                if (e.front_first !== out_ch.data.front_first ||
                    e.front_second !== out_ch.data.front_second ||
                    e.right_first !== out_ch.data.right_first ||
                    e.right_second !== out_ch.data.right_second ||
                    e.back_first !== out_ch.data.back_first ||
                    e.back_second !== out_ch.data.back_second ||
                    e.left_first !== out_ch.data.left_first)
                begin
                    $display("%0t: report mismatch, expected %h, actual %h",
                             $time, e, out_ch.data);
                    errors++;
                end
            end
        end
    end

    // Ready toggles in bursts of stall and go.
    initial
    begin
        out_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (gaps_on && $urandom_range(0, 1))
            begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
    end

    // Watchdog: any accepted beat resets the count.
    always @(negedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WatchLimit)
        begin
            $display("lidar_packet_sector_binner_tb: done, errors");
            $finish;
        end
    end

    initial
    begin
        gaps_on     = 1'b1;
        phase       = lpsb_tb_pkg::PH_HDR1;
        pkt_flag    = 1'b0;
        pkt_count   = '0;
        raw_start   = '0;
        raw_end     = '0;
        byte_idx    = '0;
        low_byte    = '0;
        step        = '0;
        cur_angle   = '0;
        snap_due    = 1'b0;
        held_snap   = '0;
        tol         = lpsb_pkg::TolReset;
        for (int i = 0; i < 7; i++) slots[i] = '0;
        for (int i = 0; i < 4; i++) hits[i] = '0;
        rst_n           <= 1'b0;
        in_ch.valid     <= 1'b0;
        in_ch.rx_byte   <= '0;
        cfg_ch.valid    <= 1'b0;
        cfg_ch.tol_word <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_framing();
        test_sectors();
        write_tol(14'd0);
        test_sectors();
        write_tol(14'd11520);
        test_sectors();
        test_random(170);
        write_tol(14'($urandom_range(0, 11520)));
        test_random(170);
        write_tol(14'($urandom_range(0, 800)));
        gaps_on = 1'b0;                     // last stretch at full rate
        test_random(170);
        drain();

        if (errors == 0)
            $display("lidar_packet_sector_binner_tb: done, clean");
        else
            $display("lidar_packet_sector_binner_tb: done, errors");
        $finish;
    end

endmodule

// File: files.f
rtl/lpsb_pkg.sv
rtl/lpsb_if.sv
rtl/lpsb_divider.sv
rtl/lidar_packet_sector_binner.sv
test/lpsb_tb_if.sv
test/lidar_packet_sector_binner_tb.sv
